FILE: rtl/wilder_rsi_indicator_assert.svh
// assertion macros shared by the rsi indicator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef WILDER_RSI_INDICATOR_ASSERT_SVH
`define WILDER_RSI_INDICATOR_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define WRSI_ASSERT_SAME(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the cycle after the antecedent
`define WRSI_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wrsi_pkg.sv
// shared widths, constants and control structs of the rsi indicator
// no dependencies; used by the interfaces, the divider and the top level
package wrsi_pkg;

    // field and state widths
    localparam int PRICE_W      = 32;
    localparam int FRAC_W       = 16;
    localparam int AVG_W        = 56;
    localparam int PERIOD_W     = 9;
    localparam int SEEN_W       = 10;
    localparam int RSI_W        = 14;

    // period limits and reset value
    localparam int MAX_PERIOD   = 256;
    localparam int PERIOD_RESET = 14;

    // full scale rsi in hundredths of a percent
    localparam int RSI_SCALE    = 10000;

    // shared divider: dividend width, divisor width, steps of the ratio division
    localparam int DIV_W        = 64;
    localparam int DIVISOR_W    = 50;
    localparam int RSI_STEPS    = DIV_W - DIVISOR_W;

    // divider request and response
    typedef struct packed {
        logic start;
        logic short_run;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

endpackage

FILE: rtl/wrsi_if.sv
// valid/ready channel interfaces for price beats and result beats
// depends on wrsi_pkg for field widths
interface wrsi_price_if import wrsi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] price;

    modport source (output valid, output price, input ready);
    modport sink (input valid, input price, output ready);
endinterface

interface wrsi_result_if import wrsi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RSI_W-1:0] rsi;
    logic             ready_res;

    modport source (output valid, output rsi, output ready_res, input ready);
    modport sink (input valid, input rsi, input ready_res, output ready);
endinterface

FILE: rtl/wrsi_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on wrsi_pkg; full run takes DIV_W steps, short run RSI_STEPS steps
module wrsi_divider import wrsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output div_rsp_t             rsp,
    output logic [DIV_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIVISOR_W-1:0] rem_reg,  rem_next;
    logic [DIV_W-1:0]     work_reg, work_next;
    logic [DIVISOR_W-1:0] dvs_reg,  dvs_next;
    logic [CNT_W-1:0]     cnt_reg,  cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIVISOR_W:0]   trial;
    logic                 take;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, work_reg[DIV_W-1]};
    assign take  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        work_next = work_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dvs_next  = divisor;
            busy_next = 1'b1;
            if (req.short_run)
            begin
                // quotient known to fit RSI_STEPS bits: skip the leading zero steps
                rem_next  = dividend[DIV_W-1:RSI_STEPS];
                work_next = {dividend[RSI_STEPS-1:0], {DIVISOR_W{1'b0}}};
                cnt_next  = CNT_W'(RSI_STEPS);
            end
            else
            begin
                rem_next  = '0;
                work_next = dividend;
                cnt_next  = CNT_W'(DIV_W);
            end
        end
        else if (busy_reg)
        begin
            if (take)
                rem_next = DIVISOR_W'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[DIVISOR_W-1:0];
            work_next = {work_reg[DIV_W-2:0], take};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quotient = work_reg;

endmodule

FILE: rtl/wilder_rsi_indicator.sv
// channel   | dir | payload               | handshake
// samples   | in  | price[31:0]           | valid / ready
// results   | out | rsi[13:0], ready_res  | valid / ready
// period    | in  | period_wdata[8:0]     | period_we, no wait
//
// one price beat at a time; ready is high only while the sequencer is idle
// first and seeding beats go from idle to done; the last one divides both sums
// smoothed beat: both averages, then the ratio, on the shared serial divider
//   (64 steps per average update, 14 for the ratio) plus up to 7 halving steps
// reset clears control and indicator state, loads period 14; no clearing pass
// a held result stalls the block until results.ready takes it
// depends on wrsi_pkg, wrsi_if, wrsi_divider and the assertion macro header
module wilder_rsi_indicator import wrsi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                period_we,
    input  logic [PERIOD_W-1:0] period_wdata,
    wrsi_price_if.sink          samples,
    wrsi_result_if.source       results
);

`include "wilder_rsi_indicator_assert.svh"

    localparam int MUL_B_W = RSI_W;
    localparam int MUL_P_W = AVG_W + MUL_B_W;
    localparam logic [RSI_W-1:0] RSI_FULL = RSI_W'(RSI_SCALE);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_SDIV_G = 11'b000_0000_0010,
        S_SDIV_L = 11'b000_0000_0100,
        S_MUL_G  = 11'b000_0000_1000,
        S_DIV_G  = 11'b000_0001_0000,
        S_MUL_L  = 11'b000_0010_0000,
        S_DIV_L  = 11'b000_0100_0000,
        S_HALVE  = 11'b000_1000_0000,
        S_MUL_R  = 11'b001_0000_0000,
        S_DIV_R  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic                 start_reg, start_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [SEEN_W-1:0]    seen_reg, seen_next;
    logic [PRICE_W-1:0]   last_price_reg, last_price_next;
    logic [AVG_W-1:0]     gavg_reg, gavg_next;
    logic [AVG_W-1:0]     lavg_reg, lavg_next;

    logic [DIV_W-1:0]     div_arg_reg, div_arg_next;
    logic [PRICE_W-1:0]   gmove_reg, gmove_next;
    logic [PRICE_W-1:0]   lmove_reg, lmove_next;
    logic [AVG_W-1:0]     rg_reg, rg_next;
    logic [AVG_W-1:0]     rl_reg, rl_next;
    logic [DIVISOR_W-1:0] s_reg, s_next;
    logic [RSI_W-1:0]     rsi_reg, rsi_next;
    logic                 rr_reg, rr_next;

    logic [PERIOD_W-1:0]  eff_p;
    logic [SEEN_W-1:0]    seen_lim;
    logic [SEEN_W-1:0]    seed_last;
    logic [SEEN_W-1:0]    seen_clamp;
    logic [SEEN_W-1:0]    seen_new;
    logic [PRICE_W-1:0]   gain_diff;
    logic [PRICE_W-1:0]   loss_diff;
    logic [AVG_W-1:0]     gsum;
    logic [AVG_W-1:0]     lsum;
    logic [AVG_W:0]       rsum;

    logic [AVG_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [DIV_W-1:0]     mul_add;
    logic [MUL_P_W-1:0]   mul_prod;
    logic [DIV_W-1:0]     mul_sum;

    div_req_t             div_req;
    div_rsp_t             div_rsp;
    logic [DIVISOR_W-1:0] div_divisor;
    logic [DIV_W-1:0]     div_q;

    // effective period: zero acts as one, large values clip
    always_comb
    begin
        if (period_reg == '0)
            eff_p = PERIOD_W'(1);
        else if (period_reg > PERIOD_W'(MAX_PERIOD))
            eff_p = PERIOD_W'(MAX_PERIOD);
        else
            eff_p = period_reg;
    end

    // sample count clamp and advance
    assign seen_lim   = SEEN_W'(eff_p) + SEEN_W'(2);
    assign seed_last  = SEEN_W'(eff_p) + SEEN_W'(1);
    assign seen_clamp = (seen_reg > seen_lim) ? seen_lim : seen_reg;
    assign seen_new   = (seen_clamp < seen_lim) ? (seen_clamp + SEEN_W'(1)) : seen_clamp;

    // price move split into gain and loss
    always_comb
    begin
        if (samples.price > last_price_reg)
        begin
            gain_diff = samples.price - last_price_reg;
            loss_diff = '0;
        end
        else
        begin
            gain_diff = '0;
            loss_diff = last_price_reg - samples.price;
        end
    end

    assign gsum = gavg_reg + AVG_W'({gain_diff, {FRAC_W{1'b0}}});
    assign lsum = lavg_reg + AVG_W'({loss_diff, {FRAC_W{1'b0}}});

    // ratio operands: sum of the averages for the halving check
    assign rsum = {1'b0, rg_reg} + {1'b0, rl_reg};

    // shared multiply-add operand select
    always_comb
    begin
        mul_a   = rg_reg;
        mul_b   = MUL_B_W'(RSI_SCALE);
        mul_add = '0;
        if (state_reg == S_MUL_G)
        begin
            mul_a   = gavg_reg;
            mul_b   = MUL_B_W'(eff_p - PERIOD_W'(1));
            mul_add = DIV_W'({gmove_reg, {FRAC_W{1'b0}}});
        end
        else if (state_reg == S_MUL_L)
        begin
            mul_a   = lavg_reg;
            mul_b   = MUL_B_W'(eff_p - PERIOD_W'(1));
            mul_add = DIV_W'({lmove_reg, {FRAC_W{1'b0}}});
        end
    end

    assign mul_prod = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    assign mul_sum  = mul_prod[DIV_W-1:0] + mul_add;

    // shared divider
    assign div_req.start     = start_reg;
    assign div_req.short_run = (state_reg == S_DIV_R);
    assign div_divisor       = (state_reg == S_DIV_R) ? s_reg : DIVISOR_W'(eff_p);

    wrsi_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_arg_reg),
        .divisor  (div_divisor),
        .rsp      (div_rsp),
        .quotient (div_q)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        start_next      = 1'b0;
        period_next     = period_reg;
        seen_next       = seen_reg;
        last_price_next = last_price_reg;
        gavg_next       = gavg_reg;
        lavg_next       = lavg_reg;
        div_arg_next    = div_arg_reg;
        gmove_next      = gmove_reg;
        lmove_next      = lmove_reg;
        rg_next         = rg_reg;
        rl_next         = rl_reg;
        s_next          = s_reg;
        rsi_next        = rsi_reg;
        rr_next         = rr_reg;

        if (period_we)
            period_next = period_wdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    seen_next       = seen_new;
                    last_price_next = samples.price;
                    rsi_next        = '0;
                    rr_next         = 1'b0;
                    if (seen_new == SEEN_W'(1))
                        state_next = S_DONE;
                    else if (seen_new <= seed_last)
                    begin
                        gavg_next = gsum;
                        lavg_next = lsum;
                        if (seen_new == seed_last)
                        begin
                            div_arg_next = DIV_W'(gsum);
                            start_next   = 1'b1;
                            state_next   = S_SDIV_G;
                        end
                        else
                            state_next = S_DONE;
                    end
                    else
                    begin
                        gmove_next = gain_diff;
                        lmove_next = loss_diff;
                        state_next = S_MUL_G;
                    end
                end
            end
            S_SDIV_G:
            begin
                if (div_rsp.done)
                begin
                    gavg_next    = div_q[AVG_W-1:0];
                    div_arg_next = DIV_W'(lavg_reg);
                    start_next   = 1'b1;
                    state_next   = S_SDIV_L;
                end
            end
            S_SDIV_L:
            begin
                if (div_rsp.done)
                begin
                    lavg_next  = div_q[AVG_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_MUL_G:
            begin
                div_arg_next = mul_sum;
                start_next   = 1'b1;
                state_next   = S_DIV_G;
            end
            S_DIV_G:
            begin
                if (div_rsp.done)
                begin
                    gavg_next  = div_q[AVG_W-1:0];
                    state_next = S_MUL_L;
                end
            end
            S_MUL_L:
            begin
                div_arg_next = mul_sum;
                start_next   = 1'b1;
                state_next   = S_DIV_L;
            end
            S_DIV_L:
            begin
                if (div_rsp.done)
                begin
                    lavg_next = div_q[AVG_W-1:0];
                    rr_next   = 1'b1;
                    if (div_q[AVG_W-1:0] == '0)
                    begin
                        rsi_next   = RSI_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rg_next    = gavg_reg;
                        rl_next    = div_q[AVG_W-1:0];
                        state_next = S_HALVE;
                    end
                end
            end
            S_HALVE:
            begin
                // bring the sum below 2^50 before the ratio
                if (|rsum[AVG_W:DIVISOR_W])
                begin
                    rg_next = rg_reg >> 1;
                    rl_next = rl_reg >> 1;
                end
                else if (rsum == '0)
                begin
                    rsi_next   = RSI_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    s_next     = rsum[DIVISOR_W-1:0];
                    state_next = S_MUL_R;
                end
            end
            S_MUL_R:
            begin
                div_arg_next = mul_sum;
                start_next   = 1'b1;
                state_next   = S_DIV_R;
            end
            S_DIV_R:
            begin
                if (div_rsp.done)
                begin
                    rsi_next   = div_q[RSI_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (results.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and indicator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_reg      <= 1'b0;
            period_reg     <= PERIOD_W'(PERIOD_RESET);
            seen_reg       <= '0;
            last_price_reg <= '0;
            gavg_reg       <= '0;
            lavg_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            start_reg      <= start_next;
            period_reg     <= period_next;
            seen_reg       <= seen_next;
            last_price_reg <= last_price_next;
            gavg_reg       <= gavg_next;
            lavg_reg       <= lavg_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        div_arg_reg <= div_arg_next;
        gmove_reg   <= gmove_next;
        lmove_reg   <= lmove_next;
        rg_reg      <= rg_next;
        rl_reg      <= rl_next;
        s_reg       <= s_next;
        rsi_reg     <= rsi_next;
        rr_reg      <= rr_next;
    end

    // channel outputs
    assign samples.ready     = (state_reg == S_IDLE);
    assign results.valid     = (state_reg == S_DONE);
    assign results.rsi       = rsi_reg;
    assign results.ready_res = rr_reg;

    // checks
    `WRSI_ASSERT_SAME(a_rsi_range, clk, rst_n, results.valid, results.rsi <= RSI_FULL,
        "rsi beyond full scale")
    `WRSI_ASSERT_SAME(a_seed_zero, clk, rst_n, results.valid && !results.ready_res,
        results.rsi == '0, "seeding beat carries nonzero rsi")
    `WRSI_ASSERT_SAME(a_one_item, clk, rst_n, samples.ready, !results.valid,
        "input ready while a result is held")
    `WRSI_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, samples.valid && samples.ready,
        !samples.ready, "ready again right after an accepted beat")
    `WRSI_ASSERT_SAME(a_div_owner, clk, rst_n, div_rsp.busy || div_rsp.done,
        state_reg == S_SDIV_G || state_reg == S_SDIV_L || state_reg == S_DIV_G ||
        state_reg == S_DIV_L || state_reg == S_DIV_R, "divider active outside a divide step")

endmodule

FILE: test/tb_wilder_rsi_indicator.sv
`timescale 1ns / 1ps
// self-checking testbench for wilder_rsi_indicator: price beats in, rsi beats checked out
// depends on wrsi_pkg, the wrsi_if channel interfaces and the rtl top level
module tb_wilder_rsi_indicator;
    import wrsi_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYC     = 5;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYC    = 400;
    localparam int SUM_LIMIT_BIT = 50;
    localparam logic [PRICE_W-1:0] PRICE_TOP = '1;

    typedef struct packed {
        logic [RSI_W-1:0] rsi;
        logic             ready_res;
    } rsi_beat_t;

    logic                clk;
    logic                rst_n;
    logic                period_we;
    logic [PERIOD_W-1:0] period_wdata;

    wrsi_price_if  samples_ch ();
    wrsi_result_if results_ch ();

    wilder_rsi_indicator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .period_we    (period_we),
        .period_wdata (period_wdata),
        .samples      (samples_ch),
        .results      (results_ch)
    );

    // predicted indicator state
    logic [PERIOD_W-1:0] model_period;
    logic [SEEN_W-1:0]   model_seen;
    logic [PRICE_W-1:0]  model_last;
    logic [AVG_W-1:0]    model_gain_avg;
    logic [AVG_W-1:0]    model_loss_avg;

    logic [PRICE_W-1:0] price_backlog[$];
    rsi_beat_t          rsi_expected[$];
    int unsigned        send_gap_pct;
    int unsigned        take_stall_pct;
    int unsigned        mismatch_count = 0;
    int unsigned        cycle_count = 0;

    // advance the predicted state by one price and return the rsi beat it yields
    function automatic rsi_beat_t next_rsi(input logic [PRICE_W-1:0] px);
        bit [63:0] per;
        bit [63:0] gain;
        bit [63:0] loss;
        bit [63:0] g;
        bit [63:0] l;
        bit [63:0] s;
        bit [63:0] ratio;
        rsi_beat_t beat;
        beat = '0;
        gain = '0;
        loss = '0;
        per = (model_period == 0) ? 1 : (model_period > MAX_PERIOD) ? MAX_PERIOD : model_period;
        // clamp after a period change, then count this price
        if (model_seen > per + 2)
            model_seen = SEEN_W'(per + 2);
        if (model_seen < per + 2)
            model_seen = model_seen + 1'b1;
        if (model_seen == 1)
        begin
            model_last = px;
            return beat;
        end
        // a flat price counts as a zero loss
        if (px > model_last)
            gain = {32'd0, px - model_last} << FRAC_W;
        else
            loss = {32'd0, model_last - px} << FRAC_W;
        model_last = px;
        // seeding window: accumulate sums, divide on the last one
        if (model_seen <= per + 1)
        begin
            g = model_gain_avg;
            l = model_loss_avg;
            model_gain_avg = AVG_W'(g + gain);
            model_loss_avg = AVG_W'(l + loss);
            if (model_seen == per + 1)
            begin
                g = model_gain_avg;
                l = model_loss_avg;
                model_gain_avg = AVG_W'(g / per);
                model_loss_avg = AVG_W'(l / per);
            end
            return beat;
        end
        // wilder smoothing
        g = model_gain_avg;
        l = model_loss_avg;
        g = (g * (per - 1) + gain) / per;
        l = (l * (per - 1) + loss) / per;
        model_gain_avg = AVG_W'(g);
        model_loss_avg = AVG_W'(l);
        g = model_gain_avg;
        l = model_loss_avg;
        // ratio, with halving when the sum gets too wide
        if (l == 0)
            ratio = RSI_SCALE;
        else
        begin
            s = g + l;
            while ((s >> SUM_LIMIT_BIT) != 0)
            begin
                g = g >> 1;
                l = l >> 1;
                s = g + l;
            end
            if (s == 0)
                ratio = RSI_SCALE;
            else
                ratio = (g * RSI_SCALE) / s;
        end
        beat.rsi = ratio[RSI_W-1:0];
        beat.ready_res = 1'b1;
        return beat;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    // wait until every price is taken and every rsi beat has come back
    task automatic drain_all();
        while (price_backlog.size() != 0 || samples_ch.valid || rsi_expected.size() != 0)
            @(negedge clk);
    endtask

    // period write, only with the block idle
    task automatic set_period(input logic [PERIOD_W-1:0] value);
        drain_all();
        @(posedge clk);
        period_we    <= 1'b1;
        period_wdata <= value;
        @(posedge clk);
        period_we    <= 1'b0;
        model_period = value;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // cycle count for the timeout
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // price driver: predicts each beat as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_ch.valid <= 1'b0;
            samples_ch.price <= '0;
        end
        else
        begin
            if (samples_ch.valid && samples_ch.ready)
                rsi_expected.insert(rsi_expected.size(), next_rsi(samples_ch.price));
            // offer the next price once the current one is gone
            if (!samples_ch.valid || samples_ch.ready)
            begin
                if (price_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    samples_ch.valid <= 1'b1;
                    samples_ch.price <= price_backlog.pop_front();
                end
                else
                    samples_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor: compares each beat with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        rsi_beat_t want;
        if (!rst_n)
            results_ch.ready <= 1'b0;
        else
        begin
            if (results_ch.valid && results_ch.ready)
            begin
                if (rsi_expected.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = rsi_expected.pop_front();
                    if (results_ch.rsi !== want.rsi)
                        report_mismatch($sformatf("rsi %0d, expected %0d",
                                                  results_ch.rsi, want.rsi));
                    if (results_ch.ready_res !== want.ready_res)
                        report_mismatch($sformatf("ready_res %0b, expected %0b",
                                                  results_ch.ready_res, want.ready_res));
                end
            end
            results_ch.ready <= ($urandom_range(99) >= take_stall_pct);
        end
    end

    // stimulus
    initial
    begin : stimulus
        int unsigned         issued;
        int unsigned         n;
        int unsigned         eff;
        int unsigned         pick;
        int unsigned         step;
        logic [PERIOD_W-1:0] new_period;
        logic [PRICE_W-1:0]  walk;

        rst_n            = 1'b0;
        period_we        = 1'b0;
        period_wdata     = '0;
        model_period     = PERIOD_RESET;
        model_seen       = '0;
        model_last       = '0;
        model_gain_avg   = '0;
        model_loss_avg   = '0;
        send_gap_pct     = 21;
        take_stall_pct   = 72;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        // period 2: full-scale rise through seeding, then falls and a flat price
        set_period(9'd2);
        price_backlog = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h0};

        // period 0 acts as 1: both averages zero, pure gain, pure loss, extremes
        set_period('0);
        price_backlog = '{32'd5, 32'd5, 32'd7, 32'd3, 32'hFFFF_FFFF, 32'h0};

        // above the maximum acts as 256: back in the seeding window, sums resume
        set_period(9'h1FF);
        price_backlog = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000};

        // random phases: a period per phase, prices as a random walk with jumps
        walk = $urandom;
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                new_period = '0;
            else if (pick < 18)
                new_period = PERIOD_W'(MAX_PERIOD);
            else if (pick < 23)
                new_period = 9'h1FF;
            else if (pick < 30)
                new_period = 9'd1;
            else if (pick < 40)
                new_period = PERIOD_W'($urandom_range(0, 511));
            else
                new_period = PERIOD_W'($urandom_range(2, 20));
            set_period(new_period);

            // idling pattern by progress through the random part
            if (issued < RANDOM_ITEMS / 3)
            begin
                send_gap_pct   = 21;
                take_stall_pct = 72;
            end
            else if (issued < 2 * RANDOM_ITEMS / 3)
            begin
                send_gap_pct   = 72;
                take_stall_pct = 21;
            end
            else
            begin
                send_gap_pct   = 0;
                take_stall_pct = 0;
            end

            eff = (new_period == 0) ? 1 : (new_period > MAX_PERIOD) ? MAX_PERIOD : new_period;
            n = (eff > 30) ? $urandom_range(10, eff + 40) : $urandom_range(20, 80);
            repeat (n)
            begin
                pick = $urandom_range(99);
                if (pick < 5)
                    walk = $urandom;
                else if (pick < 8)
                    walk = '0;
                else if (pick < 11)
                    walk = PRICE_TOP;
                else if (pick >= 20)
                begin
                    // log-spread step size, saturating at the price range
                    step = $urandom_range(0, 32'd1 << $urandom_range(0, 31));
                    if ($urandom_range(1) == 1)
                        walk = (walk > PRICE_TOP - step) ? PRICE_TOP : walk + step;
                    else
                        walk = (walk < step) ? '0 : walk - step;
                end
                price_backlog.insert(price_backlog.size(), walk);
            end
            issued += n;
        end

        drain_all();
        repeat (SETTLE_CYC) @(posedge clk);
        if (rsi_expected.size() != 0)
            report_mismatch($sformatf("%0d rsi beats never arrived", rsi_expected.size()));
        if (mismatch_count == 0)
            $display("tb_wilder_rsi_indicator: done, clean");
        else
            $display("tb_wilder_rsi_indicator: done, errors");
        $finish;
    end

    // timeout
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t ns timeout after %0d cycles", $time, cycle_count);
        $display("tb_wilder_rsi_indicator: done, errors");
        $finish;
    end

endmodule
